[rtl/button_click_hold_detector_core_macros.svh]
// Assertion macros shared by the click and hold detector RTL.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge out of reset.
`define BCHD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: invariant");

// Check that the consequent holds in the same cycle as the antecedent.
`define BCHD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent.
`define BCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BCHD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BCHD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/bchd_pkg.sv]
// Types and constants of the button click and hold detector.
package bchd_pkg;

    localparam int CODE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int IDX_W    = 4;
    localparam int MASK_W   = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [HOLD_W-1:0] HOLD_RESET_MS = 16'd500;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TIME   = 8'd0,
        CFG_DPAD_CODES  = 8'd1,
        CFG_BTN_LOW     = 8'd2,
        CFG_BTN_HIGH    = 8'd3
    } cfg_reg_t;

endpackage

[rtl/button_click_hold_detector_core.sv]
// Top level of the button click and hold detector.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready   | kind, connected, dpad/button code, now_ms, slot
//  m_      | out       | m_valid / m_ready   | click, hold_mask, pressed_mask
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
//  One item per cycle sustained while results are taken; an accepted item passes the
//  input register, then slot compare and timer logic into the result register.
//  The slot state updates when an item moves from the input to the result register.
//  Reset (aresetn low, synchronous) clears flags, press times and both stages and
//  loads the hold time with 500 ms; slot codes reset to zero.
//  A stalled result holds the pipe; s_ready stays high while the input stage can drain.
module button_click_hold_detector_core #(
    parameter int DPAD_SLOTS   = 4,
    parameter int BUTTON_SLOTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic                            s_connected,
    input  logic [bchd_pkg::CODE_W-1:0]     s_dpad_code,
    input  logic [bchd_pkg::CODE_W-1:0]     s_button_code,
    input  logic [bchd_pkg::TIME_W-1:0]     s_now_ms,
    input  logic [bchd_pkg::IDX_W-1:0]      s_slot_index,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_click,
    output logic [bchd_pkg::MASK_W-1:0]     m_hold_mask,
    output logic [bchd_pkg::MASK_W-1:0]     m_pressed_mask,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bchd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bchd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bchd_pkg::*;

`include "button_click_hold_detector_core_macros.svh"

    localparam int TOTAL_SLOTS = DPAD_SLOTS + BUTTON_SLOTS;

    // Configuration registers
    logic [HOLD_W-1:0]     hold_time_reg;
    logic [CFG_DATA_W-1:0] dpad_codes_reg;
    logic [CFG_DATA_W-1:0] btn_low_reg;
    logic [CFG_DATA_W-1:0] btn_high_reg;

    // Input stage
    logic                  in_vld_reg;
    logic                  in_kind_reg;
    logic                  in_conn_reg;
    logic [CODE_W-1:0]     in_dpad_reg;
    logic [CODE_W-1:0]     in_button_reg;
    logic [TIME_W-1:0]     in_now_reg;
    logic [IDX_W-1:0]      in_idx_reg;

    // Slot state
    logic [TOTAL_SLOTS-1:0] pressed_reg, pressed_next;
    logic [TOTAL_SLOTS-1:0] click_reg, click_next;
    logic [TOTAL_SLOTS-1:0] held_reg, held_next;
    logic [TIME_W-1:0]      press_time_reg  [TOTAL_SLOTS];
    logic [TIME_W-1:0]      press_time_next [TOTAL_SLOTS];

    // Result stage
    logic                   m_valid_reg;
    logic                   m_click_reg, m_click_next;
    logic [MASK_W-1:0]      m_hold_reg, m_pressed_reg;

    // Per-slot evaluation of a sample
    logic [CODE_W-1:0]      slot_code [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] match_vec;
    logic [TOTAL_SLOTS-1:0] press_vec;
    logic [TOTAL_SLOTS-1:0] release_vec;
    logic [TOTAL_SLOTS-1:0] hold_hit_vec;
    logic [TIME_W-1:0]      base_time [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] query_sel;

    logic advance;
    logic commit;

    logic [TOTAL_SLOTS+MASK_W-1:0] held_pad;
    logic [TOTAL_SLOTS+MASK_W-1:0] pressed_pad;

    // Handshake: result stage frees when empty or taken
    assign advance   = !m_valid_reg || m_ready;
    assign commit    = in_vld_reg && advance;
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg  <= HOLD_RESET_MS;
            dpad_codes_reg <= '0;
            btn_low_reg    <= '0;
            btn_high_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_HOLD_TIME:  hold_time_reg  <= cfg_wdata[HOLD_W-1:0];
                CFG_DPAD_CODES: dpad_codes_reg <= cfg_wdata;
                CFG_BTN_LOW:    btn_low_reg    <= cfg_wdata;
                CFG_BTN_HIGH:   btn_high_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture an accepted item in the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg   <= s_kind;
            in_conn_reg   <= s_connected;
            in_dpad_reg   <= s_dpad_code;
            in_button_reg <= s_button_code;
            in_now_reg    <= s_now_ms;
            in_idx_reg    <= s_slot_index;
        end
    end

    // Slot codes, compares and hold timers
    for (genvar g = 0; g < TOTAL_SLOTS; g++) begin : g_slot
        if (g < DPAD_SLOTS) begin : g_dpad
            if (g < 4) begin : g_reg
                assign slot_code[g] = dpad_codes_reg[CODE_W*g +: CODE_W];
            end else begin : g_zero
                assign slot_code[g] = '0;
            end
            assign match_vec[g] = (in_dpad_reg == slot_code[g]);
        end else begin : g_btn
            if (g - DPAD_SLOTS < 4) begin : g_low
                assign slot_code[g] = btn_low_reg[CODE_W*(g-DPAD_SLOTS) +: CODE_W];
            end else if (g - DPAD_SLOTS < 8) begin : g_high
                assign slot_code[g] = btn_high_reg[CODE_W*(g-DPAD_SLOTS-4) +: CODE_W];
            end else begin : g_zero
                assign slot_code[g] = '0;
            end
            assign match_vec[g] = (in_button_reg == slot_code[g]);
        end

        assign press_vec[g]    = match_vec[g] && !pressed_reg[g];
        assign release_vec[g]  = !match_vec[g] && pressed_reg[g];
        assign base_time[g]    = press_vec[g] ? in_now_reg : press_time_reg[g];
        assign hold_hit_vec[g] = match_vec[g] && !held_reg[g] &&
                                 ((in_now_reg - base_time[g]) >=
                                  {{(TIME_W-HOLD_W){1'b0}}, hold_time_reg});
        assign query_sel[g]    = ({{(32-IDX_W){1'b0}}, in_idx_reg} == 32'(g));
    end

    // Next slot state and click result
    always_comb begin
        pressed_next    = pressed_reg;
        click_next      = click_reg;
        held_next       = held_reg;
        press_time_next = press_time_reg;
        m_click_next    = 1'b0;
        if (in_kind_reg == KIND_QUERY) begin
            m_click_next = |(click_reg & query_sel);
            click_next   = click_reg & ~query_sel;
        end else if (in_conn_reg) begin
            pressed_next = (pressed_reg | press_vec) & ~release_vec;
            click_next   = (click_reg | press_vec) & ~release_vec;
            held_next    = (held_reg & ~release_vec) | hold_hit_vec;
            for (int s = 0; s < TOTAL_SLOTS; s++) begin
                press_time_next[s] = hold_hit_vec[s] ? in_now_reg : base_time[s];
            end
        end
    end

    // Update slot state as an item moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= '0;
            click_reg   <= '0;
            held_reg    <= '0;
            for (int s = 0; s < TOTAL_SLOTS; s++) begin
                press_time_reg[s] <= '0;
            end
        end else if (commit) begin
            pressed_reg    <= pressed_next;
            click_reg      <= click_next;
            held_reg       <= held_next;
            press_time_reg <= press_time_next;
        end
    end

    // Trim or pad the flags to the mask width
    assign held_pad    = {{MASK_W{1'b0}}, held_next};
    assign pressed_pad = {{MASK_W{1'b0}}, pressed_next};

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_click_reg   <= m_click_next;
            m_hold_reg    <= held_pad[MASK_W-1:0];
            m_pressed_reg <= pressed_pad[MASK_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_click        = m_click_reg;
    assign m_hold_mask    = m_hold_reg;
    assign m_pressed_mask = m_pressed_reg;

    // Held and click latches only live on pressed slots
    `BCHD_ASSERT_ALWAYS(a_held_in_pressed, aclk, aresetn, (held_reg & ~pressed_reg) == '0)
    `BCHD_ASSERT_ALWAYS(a_click_in_pressed, aclk, aresetn, (click_reg & ~pressed_reg) == '0)
    // Slot state moves only when an item commits
    `BCHD_ASSERT_NEXT(a_state_quiet, aclk, aresetn, !commit,
                      $stable(pressed_reg) && $stable(held_reg) && $stable(click_reg))
    // Input back-pressure only when both stages are full and the result waits
    `BCHD_ASSERT_SAME(a_ready_low_full, aclk, aresetn, !s_ready,
                      in_vld_reg && m_valid_reg && !m_ready)

endmodule
